@@ hw/rtl/first_fit_block_allocator_defines.svh @@
// Assertion macros shared by the first-fit block allocator RTL.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define FFBA_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FFBA_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`else

`define FFBA_ASSERT_NOW(label, clk, rst_n, cond, prop, msg)
`define FFBA_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)

`endif

`endif

@@ hw/rtl/ffba_pkg.sv @@
// Package: sizes, codes and shared types of the first-fit block allocator.
`timescale 1ns / 1ps

package ffba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 24;
    localparam int ALIGN_BYTES  = 8;   // power of two

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int ADDR_W = 32;
    localparam int SIZE_W = 24;
    localparam int RND_W  = SIZE_W + 1;   // rounded size, top bit flags overflow
    localparam int RHDR_W = RND_W + 1;    // rounded size plus header
    localparam int END_W  = ADDR_W + 1;   // new break, with carry
    localparam int STAT_W = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [RND_W-1:0] RND_ADD    = RND_W'(ALIGN_BYTES - 1);
    localparam logic [RND_W-1:0] ALIGN_MASK = ~RND_W'(ALIGN_BYTES - 1);
    localparam logic [ADDR_W-1:0] LIMIT_RESET = 32'd1048576;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_REUSED   = 3'd0;
    localparam logic [STAT_W-1:0] ST_EXTENDED = 3'd1;
    localparam logic [STAT_W-1:0] ST_ZERO     = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOSPACE  = 3'd3;
    localparam logic [STAT_W-1:0] ST_FREED    = 3'd4;
    localparam logic [STAT_W-1:0] ST_IGNORED  = 3'd5;

    // request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [SIZE_W-1:0] request_bytes;
        logic [ADDR_W-1:0] release_address;
    } ffba_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        logic [STAT_W-1:0] status;
    } ffba_rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] offset;
        logic [SIZE_W-1:0] size;
        logic              avail;
    } ffba_entry_t;

    // controller -> datapath
    typedef struct packed {
        logic              load;          // capture request, restart scan
        logic              scan_run;      // advance the table scan
        logic              commit_hit;    // update matched entry, answer
        logic              commit_append; // append block at break, answer
        logic              finish;        // answer with null address and code
        logic [STAT_W-1:0] code;
    } ffba_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_free;
        logic zero_size;
        logic too_wide;
        logic null_addr;
        logic hit;
        logic miss;
        logic append_ok;
    } ffba_stat_t;

endpackage

@@ hw/rtl/ffba_datapath.sv @@
// Datapath: config registers, block table memory, scan pipeline and result register.
`timescale 1ns / 1ps

module ffba_datapath
    import ffba_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  ffba_req_t            req,
    input  ffba_cmd_t            cmd,
    output ffba_stat_t           stat,
    output logic                 done,
    output ffba_rsp_t            rsp
);

    ffba_entry_t mem [MAX_BLOCKS];

    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] limit_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [ADDR_W-1:0] break_reg;

    logic              kind_reg;
    logic [RND_W-1:0]  rounded_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] base_hdr_reg;
    logic [ADDR_W-1:0] target_reg;
    logic [RHDR_W-1:0] rnd_hdr_reg;

    logic [CNT_W-1:0]  rd_ptr_reg;
    logic [IDX_W-1:0]  chk_idx_reg;
    logic              chk_valid_reg;
    ffba_entry_t       chk_reg;

    logic              done_reg;
    ffba_rsp_t         rsp_reg;

    logic [RND_W-1:0]  rounded_next;
    logic [END_W-1:0]  end_next;
    logic              hit;
    logic              rd_en;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    ffba_entry_t       wr_data;

    assign rounded_next = ({1'b0, req.request_bytes} + RND_ADD) & ALIGN_MASK;
    assign end_next     = {1'b0, break_reg} + END_W'(rnd_hdr_reg);

    assign hit = chk_valid_reg &&
                 ((kind_reg == KIND_FREE) ? (chk_reg.offset == target_reg)
                                          : (chk_reg.avail &&
                                             ({1'b0, chk_reg.size} >= rounded_reg)));

    assign rd_en = cmd.scan_run && !hit && (rd_ptr_reg < count_reg);

    assign stat.is_free   = (kind_reg == KIND_FREE);
    assign stat.zero_size = (rounded_reg == '0);
    assign stat.too_wide  = rounded_reg[RND_W-1];
    assign stat.null_addr = (addr_reg == '0);
    assign stat.hit       = hit;
    assign stat.miss      = !chk_valid_reg && (rd_ptr_reg >= count_reg);
    assign stat.append_ok = (count_reg < CNT_W'(MAX_BLOCKS)) &&
                            (end_next <= {1'b0, limit_reg});

    // table write: flag update on a hit, new entry on an append
    always_comb
    begin
        wr_en   = 1'b0;
        wr_idx  = chk_idx_reg;
        wr_data = chk_reg;
        if (cmd.commit_hit)
        begin
            wr_en         = 1'b1;
            wr_data.avail = (kind_reg == KIND_FREE);
        end
        else if (cmd.commit_append)
        begin
            wr_en          = 1'b1;
            wr_idx         = count_reg[IDX_W-1:0];
            wr_data.offset = break_reg;
            wr_data.size   = rounded_reg[SIZE_W-1:0];
            wr_data.avail  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            chk_reg <= mem[rd_ptr_reg[IDX_W-1:0]];
        end
    end

    // request capture and derived operands
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg    <= req.kind;
            rounded_reg <= rounded_next;
            addr_reg    <= req.release_address;
        end
        base_hdr_reg <= base_reg + ADDR_W'(HEADER_BYTES);
        // taken from base_reg directly so a base write on the accepting edge is seen
        target_reg   <= addr_reg - base_reg - ADDR_W'(HEADER_BYTES);
        rnd_hdr_reg  <= RHDR_W'(rounded_reg) + RHDR_W'(HEADER_BYTES);
        if (rd_en)
        begin
            chk_idx_reg <= rd_ptr_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            limit_reg     <= LIMIT_RESET;
            count_reg     <= '0;
            break_reg     <= '0;
            rd_ptr_reg    <= '0;
            chk_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HEAP_BASE:  base_reg  <= cfg_data;
                    CFG_HEAP_LIMIT: limit_reg <= cfg_data;
                    default:        ;
                endcase
            end

            if (cmd.load)
            begin
                rd_ptr_reg    <= '0;
                chk_valid_reg <= 1'b0;
            end
            else if (cmd.scan_run && !hit)
            begin
                chk_valid_reg <= rd_en;
                if (rd_en)
                begin
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                end
            end

            if (cmd.commit_append)
            begin
                count_reg <= count_reg + 1'b1;
                break_reg <= end_next[ADDR_W-1:0];
            end

            done_reg <= cmd.commit_hit || cmd.commit_append || cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit_hit)
        begin
            if (kind_reg == KIND_FREE)
            begin
                rsp_reg.result_address <= '0;
                rsp_reg.status         <= ST_FREED;
            end
            else
            begin
                rsp_reg.result_address <= base_hdr_reg + chk_reg.offset;
                rsp_reg.status         <= ST_REUSED;
            end
        end
        else if (cmd.commit_append)
        begin
            rsp_reg.result_address <= base_hdr_reg + break_reg;
            rsp_reg.status         <= ST_EXTENDED;
        end
        else if (cmd.finish)
        begin
            rsp_reg.result_address <= '0;
            rsp_reg.status         <= cmd.code;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

@@ hw/rtl/ffba_ctrl.sv @@
// Controller: sequences request decode, table scan and commit.
`timescale 1ns / 1ps

module ffba_ctrl
    import ffba_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  ffba_stat_t stat,
    output ffba_cmd_t  cmd,
    output logic       busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_APPEND
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                cmd.finish = 1'b1;
                if (stat.is_free)
                begin
                    cmd.code = ST_IGNORED;
                    if (!stat.null_addr)
                    begin
                        cmd.finish = 1'b0;
                        state_next = S_SCAN;
                    end
                end
                else if (stat.zero_size)
                begin
                    cmd.code = ST_ZERO;
                end
                else if (stat.too_wide)
                begin
                    cmd.code = ST_NOSPACE;
                end
                else
                begin
                    cmd.finish = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.hit)
                begin
                    cmd.commit_hit = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (stat.miss)
                begin
                    if (stat.is_free)
                    begin
                        cmd.finish = 1'b1;
                        cmd.code   = ST_IGNORED;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_APPEND;
                    end
                end
            end
            S_APPEND:
            begin
                state_next = S_IDLE;
                if (stat.append_ok)
                begin
                    cmd.commit_append = 1'b1;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = ST_NOSPACE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ hw/rtl/first_fit_block_allocator.sv @@
// Top level: first-fit block allocator over a 64-entry block table.
// For null/zero/oversize requests done follows the decode step; else it follows the scan
//   (one entry read per cycle until a hit or the end of the table) and the commit.
// Throughput: one request at a time; busy is high from acceptance until the result,
//   and the next transfer can be accepted in the cycle done is high.
// The result is shown for one cycle on done; the receiver cannot stall it.
// Reset (rst_n, async low) empties the table and break, and restores heap_base/heap_limit.
`timescale 1ns / 1ps
`include "first_fit_block_allocator_defines.svh"

module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // request side: transfer when start is high and busy is low
    input  logic                 start,
    output logic                 busy,
    input  ffba_req_t            req,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    // result side: one transfer per request, valid for the cycle done is high
    output logic                 done,
    output ffba_rsp_t            rsp
);

    ffba_cmd_t  cmd;
    ffba_stat_t stat;

    // Controller walks DECODE -> SCAN -> APPEND; the datapath owns the config,
    // request and result registers, the table memory and the pipelined scan compare.
    ffba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    ffba_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .rsp       (rsp)
    );

    // an accepted request keeps the block busy until its result
    `FFBA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accept did not set busy")
    // the result strobe comes only once the controller is back at rest
    `FFBA_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy, "done while still busy")
    // free results never carry an address
    `FFBA_ASSERT_NOW(a_free_null, clk, rst_n, done && (rsp.status == ST_FREED || rsp.status == ST_IGNORED), rsp.result_address == '0, "free result with address")
    // an append is issued only when the table and limit allow it
    `FFBA_ASSERT_NOW(a_append_ok, clk, rst_n, cmd.commit_append, stat.append_ok, "append past limit or full table")

endmodule
